[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ssb_pkg.sv]
// Types, sizes and codes shared by the sprite blit modules.
package ssb_pkg;

    // Screen and texel store geometry
    localparam int SCREEN_W    = 640;
    localparam int SCREEN_H    = 480;
    localparam int TEXEL_DEPTH = 4096;
    localparam int TEXEL_AW    = $clog2(TEXEL_DEPTH);
    localparam int COL_AW      = $clog2(SCREEN_W);

    // Result queue
    localparam int OQ_DEPTH = 8;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    // Stream payload widths
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_PAD_W  = 5;
    localparam int CFG_IDX_W  = 3;

    // Operation codes
    localparam logic [1:0] OP_LOAD_TEXEL = 2'd0;
    localparam logic [1:0] OP_LOAD_DEPTH = 2'd1;
    localparam logic [1:0] OP_DRAW       = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_WIDTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_DEPTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ENABLE    = 3'd7;

    typedef struct packed {
        logic [10:0] start_x;
        logic [10:0] start_y;
        logic [31:0] scale_x;
        logic [31:0] scale_y;
        logic [6:0]  texture_width;
        logic [23:0] sprite_depth;
        logic [31:0] key_color;
        logic        key_enable;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] address;
        logic [31:0] texel_value;
        logic [23:0] wall_depth;
        logic [9:0]  offset_x;
        logic [9:0]  offset_y;
    } item_t;

    typedef struct packed {
        logic        write_valid;
        logic [9:0]  pix_x;
        logic [8:0]  pix_y;
        logic [31:0] color;
    } result_t;

endpackage

[hw/rtl/scaled_sprite_blit_depth_key.sv]
// Top level of the scaled sprite blit with depth test and color key.
//
//   Channel   Handshake               Payload
//   s_axis    s_axis_tvalid/tready    tuser: operation; tdata: load or draw fields
//   m_axis    m_axis_tvalid/tready    tuser: write_valid; tdata: pixel position, color
//   cfg       cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One request per cycle while s_axis_tready is high; a draw result passes through
// scale multiply, row multiply, depth memory read and texel memory read, then
// enters the queue and is offered on m_axis.
// Loads write memory in the stage that reads it, so later draws see them in order.
// Memories are undefined until written: no clearing pass after reset.
// A queue of 8 results decouples output stalls; s_axis_tready drops while 8 draws
// are outstanding. Configuration writes are always accepted (cfg_ready high).
module scaled_sprite_blit_depth_key (
    input  logic                               clk,
    input  logic                               rst_n,
    // Request stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [11:0] address, [43:12] texel_value, [67:44] wall_depth,
    // [77:68] offset_x, [87:78] offset_y
    input  logic [ssb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]                         s_axis_tuser,
    // Result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [9:0] pixel column, [18:10] pixel row, [50:19] color, [55:51] zero
    output logic [ssb_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [0] write_valid
    output logic                               m_axis_tuser,
    // Configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ssb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                        cfg_data
);

    ssb_pkg::cfg_t    cfg;
    ssb_pkg::item_t   item;
    ssb_pkg::result_t res;
    logic             accept;
    logic             res_valid;
    logic             space;

    // Unpack the request
    always_comb
    begin
        item.operation   = s_axis_tuser;
        item.address     = s_axis_tdata[11:0];
        item.texel_value = s_axis_tdata[43:12];
        item.wall_depth  = s_axis_tdata[67:44];
        item.offset_x    = s_axis_tdata[77:68];
        item.offset_y    = s_axis_tdata[87:78];
    end

    assign s_axis_tready = space;
    assign accept        = s_axis_tvalid && s_axis_tready;

    ssb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ssb_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_item   (item),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    ssb_outq u_outq (
        .clk           (clk),
        .rst_n         (rst_n),
        .reserve       (accept && (s_axis_tuser == ssb_pkg::OP_DRAW)),
        .push          (res_valid),
        .push_data     (res),
        .space         (space),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

[hw/rtl/ssb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ssb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/ssb_cfg.sv]
// Configuration register file of the sprite blit.
module ssb_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ssb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data,
    output ssb_pkg::cfg_t                  cfg
);

    ssb_pkg::cfg_t cfg_reg;
    ssb_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    // Decode the write request into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                ssb_pkg::REG_START_X:       cfg_next.start_x       = cfg_data[10:0];
                ssb_pkg::REG_START_Y:       cfg_next.start_y       = cfg_data[10:0];
                ssb_pkg::REG_SCALE_X:       cfg_next.scale_x       = cfg_data;
                ssb_pkg::REG_SCALE_Y:       cfg_next.scale_y       = cfg_data;
                ssb_pkg::REG_TEXTURE_WIDTH: cfg_next.texture_width = cfg_data[6:0];
                ssb_pkg::REG_SPRITE_DEPTH:  cfg_next.sprite_depth  = cfg_data[23:0];
                ssb_pkg::REG_KEY_COLOR:     cfg_next.key_color     = cfg_data;
                ssb_pkg::REG_KEY_ENABLE:    cfg_next.key_enable    = cfg_data[0];
            endcase
        end
    end

    // Hold register values, load defaults at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_x       <= 11'd0;
            cfg_reg.start_y       <= 11'd0;
            cfg_reg.scale_x       <= 32'h0001_0000;
            cfg_reg.scale_y       <= 32'h0001_0000;
            cfg_reg.texture_width <= 7'd64;
            cfg_reg.sprite_depth  <= 24'd0;
            cfg_reg.key_color     <= 32'd0;
            cfg_reg.key_enable    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/ssb_pipe.sv]
// Four-stage draw pipeline around the column depth and texel memories.
module ssb_pipe (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  ssb_pkg::item_t   in_item,
    input  ssb_pkg::cfg_t    cfg,
    output logic             res_valid,
    output ssb_pkg::result_t res
);

    // Stage 1: accepted request
    logic           v1_reg;
    ssb_pkg::item_t it1_reg;

    // Stage 2: scaled offsets and screen position
    logic        v2_reg;
    logic [1:0]  op2_reg;
    logic [11:0] addr2_reg;
    logic [31:0] texel2_reg;
    logic [23:0] wall2_reg;
    logic [25:0] tx2_reg;
    logic [25:0] ty2_reg;
    logic [11:0] sx2_reg;
    logic [11:0] sy2_reg;
    logic        on2_reg;

    // Stage 3: row product, depth read data arrives
    logic        v3_reg;
    logic [1:0]  op3_reg;
    logic [11:0] addr3_reg;
    logic [31:0] texel3_reg;
    logic [32:0] rowp3_reg;
    logic [25:0] tx3_reg;
    logic [11:0] sx3_reg;
    logic [11:0] sy3_reg;
    logic        on3_reg;

    // Stage 4: texel read data arrives
    logic        v4_reg;
    logic        ok4_reg;
    logic [9:0]  sx4_reg;
    logic [8:0]  sy4_reg;

    logic [41:0] prodx1;
    logic [41:0] prody1;
    logic [11:0] sx1;
    logic [11:0] sy1;
    logic        on1;
    logic [32:0] rowp2;
    logic [33:0] tidx3;
    logic        pre_ok3;
    logic        depth_we;
    logic        depth_re;
    logic [23:0] depth_rd;
    logic        texel_we;
    logic        texel_re;
    logic [31:0] texel_rd;
    logic        wv4;

    // Stage 1: scale offsets, place the pixel on screen
    always_comb
    begin
        prodx1 = {32'd0, it1_reg.offset_x} * {10'd0, cfg.scale_x};
        prody1 = {32'd0, it1_reg.offset_y} * {10'd0, cfg.scale_y};
        sx1    = {cfg.start_x[10], cfg.start_x} + {2'b00, it1_reg.offset_x};
        sy1    = {cfg.start_y[10], cfg.start_y} + {2'b00, it1_reg.offset_y};
        on1    = !sx1[11] && (32'(sx1) < 32'(ssb_pkg::SCREEN_W))
              && !sy1[11] && (32'(sy1) < 32'(ssb_pkg::SCREEN_H));
    end

    // Stage 2: texel row offset, column depth access
    assign rowp2    = {7'd0, ty2_reg} * {26'd0, cfg.texture_width};
    assign depth_we = v2_reg && (op2_reg == ssb_pkg::OP_LOAD_DEPTH)
                   && (32'(addr2_reg) < 32'(ssb_pkg::SCREEN_W));
    assign depth_re = v2_reg && (op2_reg == ssb_pkg::OP_DRAW) && on2_reg;

    ssb_ram #(
        .WIDTH (24),
        .DEPTH (ssb_pkg::SCREEN_W)
    ) u_depth_ram (
        .clk     (clk),
        .wr_en   (depth_we),
        .wr_addr (ssb_pkg::COL_AW'(addr2_reg)),
        .wr_data (wall2_reg),
        .rd_en   (depth_re),
        .rd_addr (ssb_pkg::COL_AW'(sx2_reg)),
        .rd_data (depth_rd)
    );

    // Stage 3: texel index, depth test, texel access
    assign tidx3    = {1'b0, rowp3_reg} + {8'd0, tx3_reg};
    assign pre_ok3  = on3_reg && (cfg.sprite_depth < depth_rd)
                   && (tidx3 < 34'(ssb_pkg::TEXEL_DEPTH));
    assign texel_we = v3_reg && (op3_reg == ssb_pkg::OP_LOAD_TEXEL)
                   && (32'(addr3_reg) < 32'(ssb_pkg::TEXEL_DEPTH));
    assign texel_re = v3_reg && (op3_reg == ssb_pkg::OP_DRAW) && pre_ok3;

    ssb_ram #(
        .WIDTH (32),
        .DEPTH (ssb_pkg::TEXEL_DEPTH)
    ) u_texel_ram (
        .clk     (clk),
        .wr_en   (texel_we),
        .wr_addr (ssb_pkg::TEXEL_AW'(addr3_reg)),
        .wr_data (texel3_reg),
        .rd_en   (texel_re),
        .rd_addr (tidx3[ssb_pkg::TEXEL_AW-1:0]),
        .rd_data (texel_rd)
    );

    // Stage 4: color key, form the result
    assign wv4 = ok4_reg && !(cfg.key_enable && (texel_rd == cfg.key_color));

    always_comb
    begin
        res_valid       = v4_reg;
        res.write_valid = wv4;
        res.pix_x       = wv4 ? sx4_reg : 10'd0;
        res.pix_y       = wv4 ? sy4_reg : 9'd0;
        res.color       = wv4 ? texel_rd : 32'd0;
    end

    // Advance stage valids; only draws go past stage 3
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg && (op3_reg == ssb_pkg::OP_DRAW);
        end
    end

    // Advance stage payloads
    always_ff @(posedge clk)
    begin
        it1_reg    <= in_item;

        op2_reg    <= it1_reg.operation;
        addr2_reg  <= it1_reg.address;
        texel2_reg <= it1_reg.texel_value;
        wall2_reg  <= it1_reg.wall_depth;
        tx2_reg    <= prodx1[41:16];
        ty2_reg    <= prody1[41:16];
        sx2_reg    <= sx1;
        sy2_reg    <= sy1;
        on2_reg    <= on1;

        op3_reg    <= op2_reg;
        addr3_reg  <= addr2_reg;
        texel3_reg <= texel2_reg;
        rowp3_reg  <= rowp2;
        tx3_reg    <= tx2_reg;
        sx3_reg    <= sx2_reg;
        sy3_reg    <= sy2_reg;
        on3_reg    <= on2_reg;

        ok4_reg    <= pre_ok3;
        sx4_reg    <= sx3_reg[9:0];
        sy4_reg    <= sy3_reg[8:0];
    end

endmodule

[hw/rtl/ssb_outq.sv]
// Result queue with credit count that throttles the input side.
module ssb_outq (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               reserve,
    input  logic                               push,
    input  ssb_pkg::result_t                   push_data,
    output logic                               space,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [ssb_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tuser
);

    ssb_pkg::result_t          q_reg [ssb_pkg::OQ_DEPTH];
    logic [ssb_pkg::OQ_AW-1:0] wr_ptr_reg;
    logic [ssb_pkg::OQ_AW-1:0] rd_ptr_reg;
    logic [ssb_pkg::OQ_AW:0]   fill_reg;
    logic [ssb_pkg::OQ_AW:0]   fill_next;
    logic [ssb_pkg::OQ_AW:0]   credit_reg;
    logic [ssb_pkg::OQ_AW:0]   credit_next;
    logic                      pop;
    ssb_pkg::result_t          head;

    assign pop         = m_axis_tvalid && m_axis_tready;
    assign fill_next   = fill_reg + (ssb_pkg::OQ_AW+1)'(push) - (ssb_pkg::OQ_AW+1)'(pop);
    assign credit_next = credit_reg + (ssb_pkg::OQ_AW+1)'(reserve)
                       - (ssb_pkg::OQ_AW+1)'(pop);

    // Allow a new request only while a queue slot is still unclaimed
    assign space = credit_reg < (ssb_pkg::OQ_AW+1)'(ssb_pkg::OQ_DEPTH);

    // Present the head entry
    assign head          = q_reg[rd_ptr_reg];
    assign m_axis_tvalid = fill_reg != '0;
    assign m_axis_tdata  = {{ssb_pkg::OUT_PAD_W{1'b0}}, head.color, head.pix_y,
                            head.pix_x};
    assign m_axis_tuser  = head.write_valid;

    // Track pointers, fill level and claimed slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            credit_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg   <= fill_next;
            credit_reg <= credit_next;
        end
    end

    // Store results
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/ssb_chk.sv]
// Port-level checker for the sprite blit, bound to the top level.
`include "assert_macros.svh"

module ssb_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [1:0]                     s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [ssb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tuser
);

    logic [7:0] pending_reg;
    logic       draw_in;
    logic       res_out;

    assign draw_in = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ssb_pkg::OP_DRAW);
    assign res_out = m_axis_tvalid && m_axis_tready;

    // Count draws accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 8'd0;
        end
        else
        begin
            pending_reg <= pending_reg + 8'(draw_in) - 8'(res_out);
        end
    end

    `SSB_ASSERT_NOW(a_no_orphan_result, clk, rst_n, m_axis_tvalid, pending_reg != 8'd0, "result without an outstanding draw")
    `SSB_ASSERT_NOW(a_skip_is_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "skipped pixel carries nonzero payload")
    `SSB_ASSERT_NOW(a_on_screen, clk, rst_n, m_axis_tvalid && m_axis_tuser, 32'(m_axis_tdata[9:0]) < 32'(ssb_pkg::SCREEN_W) && 32'(m_axis_tdata[18:10]) < 32'(ssb_pkg::SCREEN_H), "written pixel off screen")
    `SSB_ASSERT_NEXT(a_stall_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind scaled_sprite_blit_depth_key ssb_chk u_ssb_chk (.*);

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for the scaled sprite blit: load and draw requests against a pixel predictor.
module tb;

    localparam int DRAIN_CYCLES  = 16;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 205;

    // Operation code that the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [ssb_pkg::CFG_IDX_W-1:0] index;
        logic [31:0]                   data;
    } reg_write_t;

    logic                           clk           = 1'b0;
    logic                           rst_n         = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [ssb_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]                     s_axis_tuser  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [ssb_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tuser;
    logic                           cfg_valid     = 1'b0;
    logic                           cfg_ready;
    logic [ssb_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [31:0]                    cfg_data      = '0;

    // Mirror of the block's registers, at their reset values
    int          blit_start_x      = 0;
    int          blit_start_y      = 0;
    logic [31:0] blit_scale_x      = 32'h0001_0000;
    logic [31:0] blit_scale_y      = 32'h0001_0000;
    logic [6:0]  blit_tex_width    = 7'd64;
    logic [23:0] blit_sprite_depth = 24'd0;
    logic [31:0] blit_key_color    = 32'd0;
    logic        blit_key_enable   = 1'b0;

    // Predicted memory contents, and what the stimulus has already loaded
    logic [31:0] texel_mem [ssb_pkg::TEXEL_DEPTH];
    logic [23:0] depth_mem [ssb_pkg::SCREEN_W];
    bit          texel_loaded [ssb_pkg::TEXEL_DEPTH];
    bit          column_loaded [ssb_pkg::SCREEN_W];

    ssb_pkg::item_t   request_q [$];
    ssb_pkg::result_t pixel_q [$];
    reg_write_t       reg_write_q [$];

    ssb_pkg::item_t   req_cur;
    bit               req_busy    = 1'b0;
    int               req_gap     = 0;
    bit               send_burst  = 1'b0;
    int               out_gap     = 0;
    bit               recv_burst  = 1'b0;
    reg_write_t       cfg_cur;
    bit               cfg_busy    = 1'b0;
    ssb_pkg::result_t pred_pixel;
    ssb_pkg::result_t exp_pixel;
    ssb_pkg::result_t seen_pixel;

    int error_count    = 0;
    int draws_accepted = 0;
    int pixels_drawn   = 0;
    int loads_accepted = 0;
    int settings_count = 0;

    scaled_sprite_blit_depth_key u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Texel index from the sprite offset under the current scale
    function automatic logic [47:0] texel_index(logic [9:0] ox, logic [9:0] oy);
        logic [47:0] tx;
        logic [47:0] ty;
        tx = ({38'd0, ox} * {16'd0, blit_scale_x}) >> 16;
        ty = ({38'd0, oy} * {16'd0, blit_scale_y}) >> 16;
        return ty * {41'd0, blit_tex_width} + tx;
    endfunction

    // Pixel that one draw request produces
    function automatic ssb_pkg::result_t blit_pixel(logic [9:0] ox, logic [9:0] oy);
        int               sx;
        int               sy;
        logic [47:0]      tidx;
        logic [31:0]      c;
        ssb_pkg::result_t r;
        r    = '0;
        sx   = blit_start_x + int'(ox);
        sy   = blit_start_y + int'(oy);
        tidx = texel_index(ox, oy);
        if (sx < 0 || sx >= ssb_pkg::SCREEN_W || sy < 0 || sy >= ssb_pkg::SCREEN_H)
            return r;
        if (!(blit_sprite_depth < depth_mem[sx]))
            return r;
        if (tidx >= ssb_pkg::TEXEL_DEPTH)
            return r;
        c = texel_mem[tidx[ssb_pkg::TEXEL_AW-1:0]];
        if (blit_key_enable && c == blit_key_color)
            return r;
        r.write_valid = 1'b1;
        r.pix_x       = sx[9:0];
        r.pix_y       = sy[8:0];
        r.color       = c;
        return r;
    endfunction

    function automatic ssb_pkg::item_t blank_item(logic [1:0] op);
        ssb_pkg::item_t it;
        it.operation   = op;
        it.address     = 12'($urandom);
        it.texel_value = $urandom;
        it.wall_depth  = 24'($urandom);
        it.offset_x    = 10'($urandom);
        it.offset_y    = 10'($urandom);
        return it;
    endfunction

    // Bias texel colors toward the key and the extremes
    function automatic logic [31:0] pick_color();
        unique case ($urandom_range(0, 7))
            0, 1:    return blit_key_color;
            2:       return 32'd0;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Bias wall depths around the sprite depth
    function automatic logic [23:0] pick_wall();
        unique case ($urandom_range(0, 3))
            0:       return 24'($urandom);
            1:       return blit_sprite_depth;
            2:       return (blit_sprite_depth == 24'hFF_FFFF) ? blit_sprite_depth
                                                             : blit_sprite_depth + 24'd1;
            default: return 24'hFF_FFFF;
        endcase
    endfunction

    task automatic queue_texel(logic [11:0] addr, logic [31:0] value);
        ssb_pkg::item_t it;
        it             = blank_item(ssb_pkg::OP_LOAD_TEXEL);
        it.address     = addr;
        it.texel_value = value;
        texel_loaded[addr] = 1'b1;
        request_q.push_back(it);
    endtask

    task automatic queue_depth(logic [11:0] addr, logic [23:0] value);
        ssb_pkg::item_t it;
        it            = blank_item(ssb_pkg::OP_LOAD_DEPTH);
        it.address    = addr;
        it.wall_depth = value;
        if (addr < ssb_pkg::SCREEN_W)
            column_loaded[addr] = 1'b1;
        request_q.push_back(it);
    endtask

    // Load whatever the draw would read for the first time, then queue the draw
    task automatic queue_draw(logic [9:0] ox, logic [9:0] oy);
        ssb_pkg::item_t it;
        int             sx;
        logic [47:0]    tidx;
        sx   = blit_start_x + int'(ox);
        tidx = texel_index(ox, oy);
        if (sx >= 0 && sx < ssb_pkg::SCREEN_W && !column_loaded[sx])
            queue_depth(12'(sx), pick_wall());
        if (tidx < ssb_pkg::TEXEL_DEPTH && !texel_loaded[tidx[ssb_pkg::TEXEL_AW-1:0]])
            queue_texel(tidx[ssb_pkg::TEXEL_AW-1:0], pick_color());
        it          = blank_item(ssb_pkg::OP_DRAW);
        it.offset_x = ox;
        it.offset_y = oy;
        request_q.push_back(it);
    endtask

    task automatic queue_reg(logic [ssb_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        reg_write_t w;
        w.index = idx;
        w.data  = value;
        reg_write_q.push_back(w);
    endtask

    // Write all registers and wait for the writes to land
    task automatic set_registers(int sx, int sy, logic [31:0] scx, logic [31:0] scy,
                                 int tw, logic [23:0] sd, logic [31:0] key, bit ken);
        queue_reg(ssb_pkg::REG_START_X, 32'(sx));
        queue_reg(ssb_pkg::REG_START_Y, 32'(sy));
        queue_reg(ssb_pkg::REG_SCALE_X, scx);
        queue_reg(ssb_pkg::REG_SCALE_Y, scy);
        queue_reg(ssb_pkg::REG_TEXTURE_WIDTH, 32'(tw));
        queue_reg(ssb_pkg::REG_SPRITE_DEPTH, {8'd0, sd});
        queue_reg(ssb_pkg::REG_KEY_COLOR, key);
        queue_reg(ssb_pkg::REG_KEY_ENABLE, {31'd0, ken});
        settings_count++;
        do @(posedge clk);
        while (reg_write_q.size() != 0 || cfg_busy);
    endtask

    // Wait until every request is in and every pixel is out, then let loads retire
    task automatic settle();
        do @(posedge clk);
        while (request_q.size() != 0 || req_busy || pixel_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mostly draws across the sprite area, with loads, ignored codes and wild offsets mixed in
    task automatic queue_random(int count, int sw, int sh);
        int pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                queue_texel(12'($urandom), pick_color());
            else if (pick < 22)
                queue_depth(($urandom_range(0, 4) == 0)
                                ? 12'($urandom)
                                : 12'($urandom_range(0, ssb_pkg::SCREEN_W - 1)),
                            pick_wall());
            else if (pick < 25)
                request_q.push_back(blank_item(OP_UNUSED));
            else if (pick < 85)
                queue_draw(10'($urandom_range(0, sw + 1)), 10'($urandom_range(0, sh + 1)));
            else
                queue_draw(10'($urandom), 10'($urandom));
        end
    endtask

    // Request driver: retire accepted requests into the predictor, then present the next one
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            req_busy = 1'b0;
            req_gap  = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                unique case (req_cur.operation)
                    ssb_pkg::OP_LOAD_TEXEL:
                    begin
                        texel_mem[req_cur.address] = req_cur.texel_value;
                        loads_accepted++;
                    end
                    ssb_pkg::OP_LOAD_DEPTH:
                    begin
                        if (req_cur.address < ssb_pkg::SCREEN_W)
                            depth_mem[req_cur.address] = req_cur.wall_depth;
                        loads_accepted++;
                    end
                    ssb_pkg::OP_DRAW:
                    begin
                        pred_pixel = blit_pixel(req_cur.offset_x, req_cur.offset_y);
                        pixel_q.push_back(pred_pixel);
                        draws_accepted++;
                        if (pred_pixel.write_valid)
                            pixels_drawn++;
                    end
                    default:
                        ;
                endcase
                req_busy = 1'b0;
            end
            if (!req_busy && req_gap != 0)
                req_gap--;
            else if (!req_busy && request_q.size() != 0)
            begin
                req_cur  = request_q.pop_front();
                req_busy = 1'b1;
                if ($urandom_range(0, 49) == 0)
                    send_burst = !send_burst;
                req_gap = send_burst ? 0 : $urandom_range(0, 13);
                s_axis_tdata <= {req_cur.offset_y, req_cur.offset_x, req_cur.wall_depth,
                                 req_cur.texel_value, req_cur.address};
                s_axis_tuser <= req_cur.operation;
            end
            s_axis_tvalid <= req_busy;
        end
    end

    // Pixel monitor: compare each result with the oldest prediction, stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            out_gap = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_pixel.write_valid = m_axis_tuser;
                seen_pixel.pix_x       = m_axis_tdata[9:0];
                seen_pixel.pix_y       = m_axis_tdata[18:10];
                seen_pixel.color       = m_axis_tdata[50:19];
                if (pixel_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("ERROR: unexpected pixel valid=%0b x=%0d y=%0d color=%h",
                                 seen_pixel.write_valid, seen_pixel.pix_x,
                                 seen_pixel.pix_y, seen_pixel.color);
                end
                else
                begin
                    exp_pixel = pixel_q.pop_front();
                    if (seen_pixel !== exp_pixel)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display({"ERROR: pixel expected valid=%0b x=%0d y=%0d color=%h,",
                                      " got valid=%0b x=%0d y=%0d color=%h"},
                                     exp_pixel.write_valid, exp_pixel.pix_x,
                                     exp_pixel.pix_y, exp_pixel.color,
                                     seen_pixel.write_valid, seen_pixel.pix_x,
                                     seen_pixel.pix_y, seen_pixel.color);
                    end
                end
                if ($urandom_range(0, 49) == 0)
                    recv_burst = !recv_burst;
                out_gap = recv_burst ? 0 : $urandom_range(0, 13);
            end
            if (out_gap != 0)
            begin
                out_gap--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Register write driver: update the mirror on each accepted write
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_busy = 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_cur.index)
                    ssb_pkg::REG_START_X:
                        blit_start_x      = int'($signed(cfg_cur.data[10:0]));
                    ssb_pkg::REG_START_Y:
                        blit_start_y      = int'($signed(cfg_cur.data[10:0]));
                    ssb_pkg::REG_SCALE_X:       blit_scale_x      = cfg_cur.data;
                    ssb_pkg::REG_SCALE_Y:       blit_scale_y      = cfg_cur.data;
                    ssb_pkg::REG_TEXTURE_WIDTH: blit_tex_width    = cfg_cur.data[6:0];
                    ssb_pkg::REG_SPRITE_DEPTH:  blit_sprite_depth = cfg_cur.data[23:0];
                    ssb_pkg::REG_KEY_COLOR:     blit_key_color    = cfg_cur.data;
                    ssb_pkg::REG_KEY_ENABLE:    blit_key_enable   = cfg_cur.data[0];
                    default:                    ;
                endcase
                cfg_busy = 1'b0;
            end
            if (!cfg_busy && reg_write_q.size() != 0)
            begin
                cfg_cur  = reg_write_q.pop_front();
                cfg_busy = 1'b1;
                cfg_index <= cfg_cur.index;
                cfg_data  <= cfg_cur.data;
            end
            cfg_valid <= cfg_busy;
        end
    end

    // Stimulus sequence
    initial
    begin
        int          sw;
        int          sh;
        int          tw;
        int          sx0;
        int          sy0;
        logic [31:0] scx;
        logic [31:0] scy;
        logic [31:0] key;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: store extremes, ignored loads, clipping, depth fail, index overflow
        queue_depth(12'd0, 24'hFF_FFFF);
        queue_depth(12'd639, 24'd1);
        queue_depth(12'd5, 24'd0);
        queue_depth(12'd640, 24'd7);
        queue_depth(12'hFFF, 24'hFF_FFFF);
        queue_texel(12'd0, 32'hFFFF_FFFF);
        queue_texel(12'hFFF, 32'd0);
        request_q.push_back(blank_item(OP_UNUSED));
        queue_draw(10'd0, 10'd0);
        queue_draw(10'd5, 10'd0);
        queue_draw(10'd639, 10'd479);
        queue_draw(10'd640, 10'd0);
        queue_draw(10'd0, 10'd480);
        queue_draw(10'd1023, 10'd1023);
        queue_draw(10'd63, 10'd63);
        settle();

        // Zero scale so every draw reads texel zero: keyed texel hidden, then shown
        key = $urandom;
        set_registers(0, 0, 32'd0, 32'd0, 1, 24'd0, key, 1'b1);
        queue_texel(12'd0, key);
        queue_draw(10'd0, 10'd0);
        queue_texel(12'd0, key ^ 32'd1);
        queue_draw(10'd3, 10'd7);
        queue_draw(10'd600, 10'd479);
        settle();

        // Register extremes
        set_registers(-1024, -1024, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64, 24'hFF_FFFF,
                      32'hFFFF_FFFF, 1'b1);
        queue_draw(10'd1023, 10'd1023);
        queue_draw(10'd0, 10'd0);
        settle();
        set_registers(1023, 1023, 32'h0001_0000, 32'h0001_0000, 63, 24'd0, 32'd0, 1'b0);
        queue_draw(10'd0, 10'd0);
        settle();

        // Random sprites, each phase drained before the next register setting
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            tw  = $urandom_range(1, 64);
            sw  = $urandom_range(1, 160);
            sh  = $urandom_range(1, 160);
            scx = (tw * 65536) / sw;
            scy = ((ssb_pkg::TEXEL_DEPTH / tw) * 65536) / sh;
            if (p == 4)
            begin
                scx = $urandom >> $urandom_range(0, 24);
                scy = $urandom >> $urandom_range(0, 24);
            end
            sx0 = int'($urandom_range(0, ssb_pkg::SCREEN_W + sw)) - sw;
            sy0 = int'($urandom_range(0, ssb_pkg::SCREEN_H + sh)) - sh;
            set_registers(sx0, sy0, scx, scy, tw, 24'($urandom), $urandom,
                          1'($urandom_range(0, 1)));
            queue_random(PHASE_ITEMS, sw, sh);
            settle();
        end

        $display("Run covered %0d draw requests (%0d pixels written) and %0d load requests,",
                 draws_accepted, pixels_drawn, loads_accepted);
        $display("under %0d register settings with random stalls on both streams.",
                 settings_count + 1);
        if (error_count == 0 && pixel_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

[scaled_sprite_blit_depth_key.f]
+incdir+hw/rtl
hw/rtl/ssb_pkg.sv
hw/rtl/ssb_ram.sv
hw/rtl/ssb_cfg.sv
hw/rtl/ssb_pipe.sv
hw/rtl/ssb_outq.sv
hw/rtl/scaled_sprite_blit_depth_key.sv
hw/rtl/ssb_chk.sv
tb/tb.sv
